### sv/xmtc_pkg.sv
`timescale 1ns / 1ps
// xmtc_pkg: shared types, codes and keyword tables for the xml markup token classifier
// no dependencies; used by the interfaces, xmtc_char_class and xml_markup_token_classifier
package xmtc_pkg;

    localparam int CHAR_W   = 21;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 3;
    localparam int PHASE_W  = 3;
    localparam int KW_IDX_W = 3;

    // leading_mode codes
    localparam logic [MODE_W-1:0] MODE_STRICT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SKIP_WS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_MORE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WS       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PI       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DOCTYPE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COMMENT  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CDATA    = 3'd7;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXCL    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DOCTYPE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_COMMENT = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CDATA   = 3'd5;

    localparam logic [KW_IDX_W-1:0] KW_FIRST = 3'd1;
    localparam logic [KW_IDX_W-1:0] KW_LAST  = 3'd6;

    // ascii characters the parser looks for
    localparam logic [CHAR_W-1:0] CH_LT    = 21'h3C;
    localparam logic [CHAR_W-1:0] CH_QM    = 21'h3F;
    localparam logic [CHAR_W-1:0] CH_EXCL  = 21'h21;
    localparam logic [CHAR_W-1:0] CH_SLASH = 21'h2F;
    localparam logic [CHAR_W-1:0] CH_DASH  = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_D     = 21'h44;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 21'h5B;

    // per-character flags from the classifier
    typedef struct packed {
        logic is_lt;
        logic is_qm;
        logic is_excl;
        logic is_slash;
        logic is_dash;
        logic is_d;
        logic is_lbrk;
        logic is_ws;
        logic is_name_start;
    } char_flags_t;

    // letters of DOCTYPE and [CDATA[ by position
    function automatic logic [7:0] kw_char(input logic is_cdata,
                                           input logic [KW_IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (is_cdata) begin
            case (idx)
                3'd0:    ch = 8'h5B; // [
                3'd1:    ch = 8'h43; // C
                3'd2:    ch = 8'h44; // D
                3'd3:    ch = 8'h41; // A
                3'd4:    ch = 8'h54; // T
                3'd5:    ch = 8'h41; // A
                3'd6:    ch = 8'h5B; // [
                default: ch = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    ch = 8'h44; // D
                3'd1:    ch = 8'h4F; // O
                3'd2:    ch = 8'h43; // C
                3'd3:    ch = 8'h54; // T
                3'd4:    ch = 8'h59; // Y
                3'd5:    ch = 8'h50; // P
                3'd6:    ch = 8'h45; // E
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

### sv/xmtc_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the xml markup token classifier
// depends on xmtc_pkg for field widths
interface xmtc_char_if;
    import xmtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface xmtc_token_if;
    import xmtc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   token_kind;
    logic                char_consumed;
    modport source (output valid, output status, output token_kind, output char_consumed,
                    input ready);
    modport sink   (input valid, input status, input token_kind, input char_consumed,
                    output ready);
endinterface

interface xmtc_mode_if;
    import xmtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] leading_mode;
    modport source (output valid, output leading_mode, input ready);
    modport sink   (input valid, input leading_mode, output ready);
endinterface

### sv/xml_markup_token_classifier.sv
`timescale 1ns / 1ps
// xml_markup_token_classifier: top level, one code point in, one status item out
// depends on xmtc_pkg, the channel interfaces in xmtc_ifs.sv and xmtc_char_class
//
//  channel   | role   | payload                                 | moves
//  ----------+--------+-----------------------------------------+---------------------
//  char_ch   | sink   | char_code[20:0]                         | one code point
//  token_ch  | source | status[1:0], token_kind[2:0], consumed  | one result per char
//  mode_ch   | sink   | leading_mode[1:0]                       | register write
//
// one item per cycle while token_ch takes results; an item passes the input register, then the result register
// the parse step sits between the input register and the result register and
// updates the phase and keyword index when its item moves into the result register
// a stalled result register holds; the input register still takes an item when empty
// rst_n clears phase, keyword index, mode and both valid flags
module xml_markup_token_classifier (
    input  logic         clk,
    input  logic         rst_n,
    xmtc_char_if.sink    char_ch,
    xmtc_token_if.source token_ch,
    xmtc_mode_if.sink    mode_ch
);
    import xmtc_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                used_reg;

    // parser state and mode
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [KW_IDX_W-1:0] kw_idx_reg;
    logic [KW_IDX_W-1:0] kw_idx_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [MODE_W-1:0]   mode_eff;

    logic [STATUS_W-1:0] status_next;
    logic [KIND_W-1:0]   kind_next;
    logic                used_next;

    char_flags_t flags;
    logic        kw_hit;
    logic        advance;

    xmtc_char_class u_class (
        .char_code (char_reg),
        .flags     (flags)
    );

    // step moves when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || token_ch.ready);
    assign char_ch.ready = !in_valid_reg || advance;
    assign mode_ch.ready = 1'b1;

    assign token_ch.valid         = out_valid_reg;
    assign token_ch.status        = status_reg;
    assign token_ch.token_kind    = kind_reg;
    assign token_ch.char_consumed = used_reg;

    // reserved mode code behaves as strict
    assign mode_eff = (mode_reg == MODE_SKIP_WS || mode_reg == MODE_RESYNC) ? mode_reg
                                                                            : MODE_STRICT;

    // keyword letter match; index past the last letter never matches
    assign kw_hit = (kw_idx_reg <= KW_LAST) &&
                    (char_reg == {{(CHAR_W-8){1'b0}},
                                  kw_char(phase_reg == PH_CDATA, kw_idx_reg)});

    // parse step: defaults are error, back to waiting
    always_comb
    begin
        status_next = ST_ERROR;
        kind_next   = KIND_NONE;
        used_next   = 1'b0;
        phase_next  = PH_WAIT;
        kw_idx_next = '0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (flags.is_lt) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                    phase_next  = PH_TYPE;
                end else if (mode_eff == MODE_RESYNC) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                end else if (flags.is_ws) begin
                    if (mode_eff == MODE_SKIP_WS) begin
                        status_next = ST_MORE;
                        used_next   = 1'b1;
                    end else begin
                        // whitespace token, left for the next stage
                        status_next = ST_DONE;
                        kind_next   = KIND_WS;
                    end
                end
            end
            PH_TYPE:
            begin
                if (flags.is_qm) begin
                    status_next = ST_DONE;
                    kind_next   = KIND_PI;
                    used_next   = 1'b1;
                end else if (flags.is_excl) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                    phase_next  = PH_EXCL;
                end else if (flags.is_name_start) begin
                    // first name char belongs to the tag name
                    status_next = ST_DONE;
                    kind_next   = KIND_START;
                end else if (flags.is_slash) begin
                    status_next = ST_DONE;
                    kind_next   = KIND_END;
                    used_next   = 1'b1;
                end
            end
            PH_EXCL:
            begin
                if (flags.is_d) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                    phase_next  = PH_DOCTYPE;
                    kw_idx_next = KW_FIRST;
                end else if (flags.is_dash) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                    phase_next  = PH_COMMENT;
                end else if (flags.is_lbrk) begin
                    status_next = ST_MORE;
                    used_next   = 1'b1;
                    phase_next  = PH_CDATA;
                    kw_idx_next = KW_FIRST;
                end
            end
            PH_COMMENT:
            begin
                if (flags.is_dash) begin
                    status_next = ST_DONE;
                    kind_next   = KIND_COMMENT;
                    used_next   = 1'b1;
                end
            end
            PH_DOCTYPE, PH_CDATA:
            begin
                if (kw_hit) begin
                    used_next = 1'b1;
                    if (kw_idx_reg == KW_LAST) begin
                        status_next = ST_DONE;
                        kind_next   = (phase_reg == PH_DOCTYPE) ? KIND_DOCTYPE : KIND_CDATA;
                    end else begin
                        status_next = ST_MORE;
                        phase_next  = phase_reg;
                        kw_idx_next = kw_idx_reg + KW_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                // unreachable phase codes fall back to error and waiting
                status_next = ST_ERROR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            kw_idx_reg    <= '0;
            mode_reg      <= MODE_STRICT;
        end else begin
            if (char_ch.ready) begin
                in_valid_reg <= char_ch.valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                kw_idx_reg    <= kw_idx_next;
            end else if (token_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (mode_ch.valid) begin
                mode_reg <= mode_ch.leading_mode;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready) begin
            char_reg <= char_ch.char_code;
        end
        if (advance) begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            used_reg   <= used_next;
        end
    end

endmodule

### sv/xmtc_char_class.sv
`timescale 1ns / 1ps
// xmtc_char_class: flags one code point (markup punctuation, whitespace, name start)
// depends on xmtc_pkg
module xmtc_char_class (
    input  logic [xmtc_pkg::CHAR_W-1:0] char_code,
    output xmtc_pkg::char_flags_t       flags
);
    import xmtc_pkg::*;

    always_comb
    begin
        flags.is_lt    = (char_code == CH_LT);
        flags.is_qm    = (char_code == CH_QM);
        flags.is_excl  = (char_code == CH_EXCL);
        flags.is_slash = (char_code == CH_SLASH);
        flags.is_dash  = (char_code == CH_DASH);
        flags.is_d     = (char_code == CH_D);
        flags.is_lbrk  = (char_code == CH_LBRK);
        flags.is_ws    = char_code inside {21'h20, 21'h09, 21'h0D, 21'h0A};
        flags.is_name_start = char_code inside {
            21'h3A, 21'h5F,
            [21'h41 : 21'h5A], [21'h61 : 21'h7A],
            [21'hC0 : 21'hD6], [21'hD8 : 21'hF6], [21'hF8 : 21'h2FF],
            [21'h370 : 21'h37D], [21'h37F : 21'h1FFF], [21'h200C : 21'h200D],
            [21'h2070 : 21'h218F], [21'h2C00 : 21'h2FEF], [21'h3001 : 21'hD7FF],
            [21'hF900 : 21'hFDCF], [21'hFDF0 : 21'hFFFD], [21'h10000 : 21'hEFFFF]
        };
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for xml_markup_token_classifier, directed then random tokens
// depends on xmtc_pkg, the channel interfaces in xmtc_ifs.sv and the classifier itself
module tb_top;
    import xmtc_pkg::*;

    // result fields of one token item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic                consumed;
    } token_t;

    // the mode code the block has no meaning for, handled as strict
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // whitespace code points
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_TOP   = 21'h1FFFFF;

    // keyword letters, first letter in the top byte
    localparam logic [55:0] DOCTYPE_WORD = "DOCTYPE";
    localparam logic [55:0] CDATA_WORD   = "[CDATA[";

    // name start ranges used by the stimulus
    localparam int NS_RANGES = 15;
    localparam logic [CHAR_W-1:0] NS_LO [NS_RANGES] = '{
        21'h3A, 21'h5F, 21'h41, 21'h61, 21'hC0, 21'hD8, 21'hF8, 21'h370,
        21'h37F, 21'h200C, 21'h2070, 21'h2C00, 21'h3001, 21'hF900, 21'h10000};
    localparam logic [CHAR_W-1:0] NS_HI [NS_RANGES] = '{
        21'h3A, 21'h5F, 21'h5A, 21'h7A, 21'hD6, 21'hF6, 21'h2FF, 21'h37D,
        21'h1FFF, 21'h200D, 21'h218F, 21'h2FEF, 21'hD7FF, 21'hFDCF, 21'hEFFFF};

    logic clk;
    logic rst_n;

    xmtc_char_if  char_ch ();
    xmtc_token_if token_ch ();
    xmtc_mode_if  mode_ch ();

    xml_markup_token_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_ch),
        .token_ch (token_ch),
        .mode_ch  (mode_ch)
    );

    // predictor state, mirrors the block's phase, keyword position and mode
    logic [PHASE_W-1:0]  cur_phase;
    logic [KW_IDX_W-1:0] kw_pos;
    logic [MODE_W-1:0]   mode_reg;

    token_t expected_tokens [$];
    int     chars_sent;
    int     fail_count;
    int     reports;
    bit     idle_on;
    int     sink_hold_cycles;
    token_t got_token;
    token_t want_token;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well beyond the slowest passing run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_white(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // xml NameStartChar, written out range by range
    function automatic bit is_name_start(input logic [CHAR_W-1:0] c);
        return c == 21'h3A || c == 21'h5F
            || (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)
            || (c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hF6)
            || (c >= 21'hF8 && c <= 21'h2FF) || (c >= 21'h370 && c <= 21'h37D)
            || (c >= 21'h37F && c <= 21'h1FFF) || (c >= 21'h200C && c <= 21'h200D)
            || (c >= 21'h2070 && c <= 21'h218F) || (c >= 21'h2C00 && c <= 21'h2FEF)
            || (c >= 21'h3001 && c <= 21'hD7FF) || (c >= 21'hF900 && c <= 21'hFDCF)
            || (c >= 21'hFDF0 && c <= 21'hFFFD) || (c >= 21'h10000 && c <= 21'hEFFFF);
    endfunction

    // one parse step: returns the token item for c and advances the predictor state
    function automatic token_t classify_char(input logic [CHAR_W-1:0] c);
        token_t              r;
        logic [PHASE_W-1:0]  nxt_phase;
        logic [KW_IDX_W-1:0] nxt_pos;
        logic [55:0]         word;
        logic [7:0]          letter;
        r.status  = ST_ERROR;
        r.kind    = KIND_NONE;
        r.consumed = 1'b0;
        nxt_phase = PH_WAIT;
        nxt_pos   = '0;
        case (cur_phase)
            PH_WAIT:
            begin
                if (c == CH_LT)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                    nxt_phase = PH_TYPE;
                end
                else if (mode_reg == MODE_RESYNC)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                end
                else if (is_white(c))
                begin
                    // skip mode eats it, strict and the spare code report it
                    if (mode_reg == MODE_SKIP_WS)
                    begin
                        r.status = ST_MORE;
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        r.status = ST_DONE;
                        r.kind = KIND_WS;
                    end
                end
            end
            PH_TYPE:
            begin
                if (c == CH_QM)
                begin
                    r.status = ST_DONE;
                    r.kind = KIND_PI;
                    r.consumed = 1'b1;
                end
                else if (c == CH_EXCL)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                    nxt_phase = PH_EXCL;
                end
                else if (is_name_start(c))
                begin
                    // name char stays for the next stage
                    r.status = ST_DONE;
                    r.kind = KIND_START;
                end
                else if (c == CH_SLASH)
                begin
                    r.status = ST_DONE;
                    r.kind = KIND_END;
                    r.consumed = 1'b1;
                end
            end
            PH_EXCL:
            begin
                if (c == CH_D)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                    nxt_phase = PH_DOCTYPE;
                    nxt_pos = KW_FIRST;
                end
                else if (c == CH_DASH)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                    nxt_phase = PH_COMMENT;
                end
                else if (c == CH_LBRK)
                begin
                    r.status = ST_MORE;
                    r.consumed = 1'b1;
                    nxt_phase = PH_CDATA;
                    nxt_pos = KW_FIRST;
                end
            end
            PH_COMMENT:
            begin
                if (c == CH_DASH)
                begin
                    r.status = ST_DONE;
                    r.kind = KIND_COMMENT;
                    r.consumed = 1'b1;
                end
            end
            PH_DOCTYPE, PH_CDATA:
            begin
                word = (cur_phase == PH_DOCTYPE) ? DOCTYPE_WORD : CDATA_WORD;
                if (kw_pos <= KW_LAST)
                begin
                    letter = word[8 * (KW_LAST - kw_pos) +: 8];
                    if (c == {13'd0, letter})
                    begin
                        r.consumed = 1'b1;
                        if (kw_pos == KW_LAST)
                        begin
                            r.status = ST_DONE;
                            r.kind = (cur_phase == PH_DOCTYPE) ? KIND_DOCTYPE : KIND_CDATA;
                        end
                        else
                        begin
                            r.status = ST_MORE;
                            nxt_phase = cur_phase;
                            nxt_pos = kw_pos + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        cur_phase = nxt_phase;
        kw_pos = nxt_pos;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_name_start();
        int i;
        i = $urandom_range(0, NS_RANGES - 1);
        return CHAR_W'($urandom_range(NS_LO[i], NS_HI[i]));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_white();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // code point for noise: ascii, bmp, name chars, beyond unicode, any 21 bits, markup, whitespace
    function automatic logic [CHAR_W-1:0] rand_code_point();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 6))
            0: c = CHAR_W'($urandom_range(0, 127));
            1: c = CHAR_W'($urandom_range(0, 16'hFFFF));
            2: c = rand_name_start();
            3: c = CHAR_W'($urandom_range(21'h110000, CH_TOP));
            4: c = CHAR_W'($urandom);
            5:
            begin
                case ($urandom_range(0, 6))
                    0:       c = CH_LT;
                    1:       c = CH_QM;
                    2:       c = CH_EXCL;
                    3:       c = CH_SLASH;
                    4:       c = CH_DASH;
                    5:       c = CH_D;
                    default: c = CH_LBRK;
                endcase
            end
            default: c = rand_white();
        endcase
        return c;
    endfunction

    // offer one code point, predict its token item on acceptance; valid stays high after
    task automatic send_char(input logic [CHAR_W-1:0] c);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 11)
        begin
            char_ch.valid <= 1'b0;
            @(negedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= c;
        do
            @(posedge clk);
        while (!char_ch.ready);
        expected_tokens.push_back(classify_char(c));
        chars_sent++;
    endtask

    task automatic send_text(input string s, input int n);
        for (int k = 0; k < n; k++)
            send_char({13'd0, s[k]});
    endtask

    // sender pause: nothing offered until every token item is back
    task automatic drain_results();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    // mode write only with the block idle
    task automatic write_mode(input logic [MODE_W-1:0] m);
        drain_results();
        repeat (3) @(negedge clk);
        mode_ch.valid <= 1'b1;
        mode_ch.leading_mode <= m;
        do
            @(posedge clk);
        while (!mode_ch.ready);
        mode_reg = m;
        @(negedge clk);
        mode_ch.valid <= 1'b0;
    endtask

    // one markup token with random content, or noise, or a token cut short
    task automatic send_random_token();
        int    pick;
        int    n;
        bit    broken;
        string text;
        pick = $urandom_range(0, 99);
        broken = 1'b0;
        text = "";
        if (pick < 8)
            send_char(rand_code_point());
        else if (pick < 16)
            send_char(rand_white());
        else if (pick < 28)
        begin
            send_char(CH_LT);
            send_char(rand_name_start());
        end
        else
        begin
            if (pick >= 80)
            begin
                broken = 1'b1;
                pick = $urandom_range(28, 79);
            end
            if (pick < 38)
                text = "<?";
            else if (pick < 48)
                text = "</";
            else if (pick < 58)
                text = "<!DOCTYPE";
            else if (pick < 68)
                text = "<!--";
            else
                text = "<![CDATA[";
            n = broken ? $urandom_range(1, text.len() - 1) : text.len();
            send_text(text, n);
            if (broken)
                send_char(rand_code_point());
        end
    endtask

    // every token type, errors and code points beyond unicode, with each mode written in turn
    task automatic test_directed();
        write_mode(MODE_STRICT);
        send_char(CH_SPACE);
        send_text("<?", 2);
        send_text("<:", 2);
        send_text("</", 2);
        send_text("<!DOCTYPE", 9);
        send_text("<!--", 4);
        send_text("<![CDATA[", 9);
        send_char(21'h78);
        send_char(CH_TOP);
        send_char(CH_LT);
        send_char(21'h10FFFF);
        write_mode(MODE_SKIP_WS);
        send_char(CH_TAB);
        send_text("<_", 2);
        write_mode(MODE_RESYNC);
        send_char(CH_TOP);
        send_char(CH_CR);
        send_text("<!x", 3);
        write_mode(MODE_SPARE);
        send_char(CH_LF);
    endtask

    task automatic test_random_tokens(input logic [MODE_W-1:0] m, input int n);
        int target;
        write_mode(m);
        target = chars_sent + n;
        while (chars_sent < target)
            send_random_token();
    endtask

    // long stretch with no gaps on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random_tokens(MODE_STRICT, 200);
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_output_stall();
        int target;
        write_mode(MODE_SKIP_WS);
        sink_hold_cycles = 80;
        target = chars_sent + 40;
        while (chars_sent < target)
            send_random_token();
        drain_results();
    endtask

    // result receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                token_ch.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else
                token_ch.ready <= !(idle_on && $urandom_range(0, 99) < 11);
        end
    end

    // compare each token item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            got_token.status = token_ch.status;
            got_token.kind = token_ch.token_kind;
            got_token.consumed = token_ch.char_consumed;
            if (expected_tokens.size() == 0)
            begin
                fail_count++;
                if (reports < 10)
                    $display("unexpected token item: status=%0d kind=%0d consumed=%0d",
                             got_token.status, got_token.kind, got_token.consumed);
                reports++;
            end
            else
            begin
                want_token = expected_tokens.pop_front();
                if (got_token.status !== want_token.status
                    || got_token.kind !== want_token.kind
                    || got_token.consumed !== want_token.consumed)
                begin
                    fail_count++;
                    if (reports < 10)
                        $display({"mismatch: expected status=%0d kind=%0d consumed=%0d,",
                                  " got status=%0d kind=%0d consumed=%0d"},
                                 want_token.status, want_token.kind, want_token.consumed,
                                 got_token.status, got_token.kind, got_token.consumed);
                    reports++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.char_code = '0;
        mode_ch.valid = 1'b0;
        mode_ch.leading_mode = MODE_STRICT;
        cur_phase = PH_WAIT;
        kw_pos = '0;
        mode_reg = MODE_STRICT;
        chars_sent = 0;
        fail_count = 0;
        reports = 0;
        idle_on = 1'b1;
        sink_hold_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_tokens(MODE_SKIP_WS, 150);
        test_random_tokens(MODE_RESYNC, 150);
        test_random_tokens(MODE_SPARE, 100);
        test_random_tokens(MODE_STRICT, 150);
        test_no_idle();
        test_output_stall();
        test_random_tokens(MODE_RESYNC, 100);
        test_random_tokens(MODE_SKIP_WS, 200);

        // wait out the pipeline, then anything still expected is a failure
        drain_results();
        repeat (10) @(posedge clk);
        fail_count += expected_tokens.size();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
